// ===== rtl/utlf_pkg.sv =====
`default_nettype none

package utlf_pkg;

    localparam int CountBitsDefault  = 16;
    localparam int QueueDepthDefault = 4;
    localparam int MaxResults        = 3;
    localparam int OutCountBits      = 16;

    localparam logic [7:0] Lead3Mask  = 8'hf0;
    localparam logic [7:0] Lead3Code  = 8'he0;
    localparam logic [7:0] Lead2Mask  = 8'he0;
    localparam logic [7:0] Lead2Code  = 8'hc0;
    localparam logic [7:0] ContMask   = 8'hc0;
    localparam logic [7:0] ContCode   = 8'h80;

    typedef struct packed {
        logic [OutCountBits-1:0] count;
        logic                    halted;
        logic                    valid;
        logic [7:0]              code;
    } t_res;

    typedef struct packed {
        t_res [MaxResults-1:0] recs;
        logic [1:0]            nres;
    } t_entry;

    function automatic logic is_lead3(input logic [7:0] b);
        return (b & Lead3Mask) == Lead3Code;
    endfunction

    function automatic logic is_lead2(input logic [7:0] b);
        return (b & Lead2Mask) == Lead2Code;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & ContMask) == ContCode;
    endfunction

    function automatic logic [7:0] lower_plain(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5a) ? b + 8'h20 : b;
    endfunction

    function automatic logic text_ok(input logic [7:0] c);
        logic ok;
        unique case (c)
            8'h7c, 8'h80, 8'h92, 8'h99, 8'h9c, 8'ha0, 8'ha1, 8'ha2, 8'ha3,
            8'ha7, 8'ha8, 8'ha9, 8'hab, 8'hb0, 8'hb4, 8'hb7, 8'hbb, 8'hc0,
            8'hc7, 8'hc9, 8'hd6, 8'hd7, 8'hd9, 8'hdf, 8'he0, 8'he1, 8'he2,
            8'he3, 8'he4, 8'he6, 8'he7, 8'he8, 8'he9, 8'hea, 8'heb, 8'hed,
            8'hee, 8'hef, 8'hf4, 8'hf6, 8'hf8, 8'hf9, 8'hfa, 8'hfb,
            8'hfc: ok = 1'b1;
            default: ok = (c == 8'h08) || (c == 8'h09) || (c == 8'h0d) ||
                          (c == 8'h0a) || (c >= 8'h20 && c <= 8'h7e) ||
                          (c >= 8'h82 && c <= 8'h8d) ||
                          (c >= 8'h93 && c <= 8'h98);
        endcase
        return ok;
    endfunction

    function automatic logic [7:0] map3(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2);
        logic [7:0] v;
        v = 8'd0;
        if (b0 == 8'he2) begin
            if (b1 == 8'h80) begin
                unique case (b2)
                    8'h93: v = 8'd150;
                    8'h94: v = 8'd151;
                    8'h98: v = 8'd145;
                    8'h99: v = 8'h27;
                    8'h9a: v = 8'd130;
                    8'h9c: v = 8'd147;
                    8'h9d: v = 8'd148;
                    8'h9e: v = 8'd132;
                    8'ha0: v = 8'd134;
                    8'ha1: v = 8'd135;
                    8'ha2: v = 8'd149;
                    8'ha6: v = 8'd133;
                    8'hb0: v = 8'd137;
                    8'hb9: v = 8'd139;
                    8'hba: v = 8'd155;
                    default: v = 8'd0;
                endcase
            end else if (b1 == 8'h82 && b2 == 8'hac) begin
                v = 8'd128;
            end else if (b1 == 8'h84 && b2 == 8'ha2) begin
                v = 8'd153;
            end
        end
        return v;
    endfunction

    function automatic logic [7:0] map2(input logic [7:0] b0, input logic [7:0] b1);
        logic [7:0] v;
        v = 8'd0;
        unique case (b0)
            8'hc2: begin
                v = (b1 | 8'h80) & 8'hbf;
                if (v == 8'ha0) v = 8'h20;
            end
            8'hc3: v = b1 | 8'hc0;
            8'hc5: begin
                unique case (b1)
                    8'h92: v = 8'd140;
                    8'h93: v = 8'd156;
                    8'ha0: v = 8'd138;
                    8'ha1: v = 8'd154;
                    8'hb8: v = 8'd143;
                    8'hbd: v = 8'd142;
                    8'hbe: v = 8'd158;
                    default: v = 8'd0;
                endcase
            end
            8'hc6: v = (b1 == 8'h92) ? 8'd131 : 8'd0;
            8'hcb: begin
                if (b1 == 8'h86) v = 8'd136;
                else if (b1 == 8'h9c) v = 8'd152;
            end
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/utlf_front.sv =====
`default_nettype none

module utlf_front #(
    parameter int COUNT_BITS = utlf_pkg::CountBitsDefault
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_end_of_buffer,
    input  wire logic            i_queue_full,
    output logic                 o_ready,
    output logic                 o_push,
    output utlf_pkg::t_entry     o_entry
);
    import utlf_pkg::*;

    logic [7:0]            r_p0, r_p1, n_p0, n_p1;
    logic [1:0]            r_n, n_n;
    logic                  r_halt, n_halt;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;

    logic [7:0]            e_code [MaxResults];
    logic [1:0]            e_len  [MaxResults];
    logic [1:0]            e_num;
    logic [7:0]            np0, np1;
    logic [1:0]            nn;
    logic                  accept;

    logic [COUNT_BITS-1:0]    cnt;
    logic [COUNT_BITS:0]      sum;
    logic [COUNT_BITS+15:0]   ext;
    logic                     halt;
    logic [1:0]               nres;
    t_entry                   entry;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept;
    assign o_entry = entry;

    // Build the ordered list of codes that this byte emits.
    always_comb begin
        for (int k = 0; k < MaxResults; k++) begin
            e_code[k] = 8'd0;
            e_len[k]  = 2'd0;
        end
        e_num = 2'd0;
        np0   = r_p0;
        np1   = r_p1;
        nn    = 2'd0;
        if (!r_halt) begin
            unique case (r_n)
                2'd0: begin
                    if (is_lead3(i_data_byte) || is_lead2(i_data_byte)) begin
                        np0 = i_data_byte;
                        nn  = 2'd1;
                    end else begin
                        e_code[e_num] = lower_plain(i_data_byte);
                        e_len[e_num]  = 2'd1;
                        e_num         = e_num + 2'd1;
                    end
                end
                2'd1: begin
                    if (is_cont(i_data_byte)) begin
                        if (is_lead3(r_p0)) begin
                            np1 = i_data_byte;
                            nn  = 2'd2;
                        end else begin
                            e_code[e_num] = map2(r_p0, i_data_byte);
                            e_len[e_num]  = 2'd2;
                            e_num         = e_num + 2'd1;
                        end
                    end else begin
                        e_code[e_num] = lower_plain(r_p0);
                        e_len[e_num]  = 2'd1;
                        e_num         = e_num + 2'd1;
                        if (is_lead3(i_data_byte) || is_lead2(i_data_byte)) begin
                            np0 = i_data_byte;
                            nn  = 2'd1;
                        end else begin
                            e_code[e_num] = lower_plain(i_data_byte);
                            e_len[e_num]  = 2'd1;
                            e_num         = e_num + 2'd1;
                        end
                    end
                end
                default: begin
                    if (is_cont(i_data_byte)) begin
                        e_code[e_num] = map3(r_p0, r_p1, i_data_byte);
                        e_len[e_num]  = 2'd3;
                        e_num         = e_num + 2'd1;
                    end else begin
                        e_code[e_num] = lower_plain(r_p0);
                        e_len[e_num]  = 2'd1;
                        e_num         = e_num + 2'd1;
                        e_code[e_num] = lower_plain(r_p1);
                        e_len[e_num]  = 2'd1;
                        e_num         = e_num + 2'd1;
                        if (is_lead3(i_data_byte) || is_lead2(i_data_byte)) begin
                            np0 = i_data_byte;
                            nn  = 2'd1;
                        end else begin
                            e_code[e_num] = lower_plain(i_data_byte);
                            e_len[e_num]  = 2'd1;
                            e_num         = e_num + 2'd1;
                        end
                    end
                end
            endcase
            if (i_end_of_buffer && nn != 2'd0) begin
                e_code[e_num] = lower_plain(np0);
                e_len[e_num]  = 2'd1;
                e_num         = e_num + 2'd1;
                if (nn == 2'd2) begin
                    e_code[e_num] = lower_plain(np1);
                    e_len[e_num]  = 2'd1;
                    e_num         = e_num + 2'd1;
                end
            end
        end
    end

    // Check each code in order, count accepted bytes and stop at the first rejected code.
    always_comb begin
        cnt   = r_cnt;
        sum   = '0;
        ext   = '0;
        halt  = 1'b0;
        nres  = 2'd0;
        entry = '0;
        for (int k = 0; k < MaxResults; k++) begin
            if (2'(k) < e_num && !halt) begin
                if (e_code[k] == 8'd0 || !text_ok(e_code[k])) begin
                    halt                  = 1'b1;
                    ext                   = {16'd0, cnt};
                    entry.recs[k].code    = 8'd0;
                    entry.recs[k].valid   = 1'b0;
                    entry.recs[k].halted  = 1'b1;
                    entry.recs[k].count   = ext[OutCountBits-1:0];
                end else begin
                    sum                   = {1'b0, cnt} + (COUNT_BITS+1)'(e_len[k]);
                    cnt                   = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
                    ext                   = {16'd0, cnt};
                    entry.recs[k].code    = e_code[k];
                    entry.recs[k].valid   = 1'b1;
                    entry.recs[k].halted  = 1'b0;
                    entry.recs[k].count   = ext[OutCountBits-1:0];
                end
                nres = 2'(k + 1);
            end
        end
        if (e_num == 2'd0) begin
            ext                  = {16'd0, r_cnt};
            entry.recs[0].halted = r_halt;
            entry.recs[0].count  = ext[OutCountBits-1:0];
            nres                 = 2'd1;
        end
        entry.nres = nres;
    end

    always_comb begin
        n_p0   = r_p0;
        n_p1   = r_p1;
        n_n    = r_n;
        n_halt = r_halt;
        n_cnt  = r_cnt;
        if (accept) begin
            if (i_end_of_buffer) begin
                n_p0   = 8'd0;
                n_p1   = 8'd0;
                n_n    = 2'd0;
                n_halt = 1'b0;
                n_cnt  = '0;
            end else if (halt) begin
                n_n    = 2'd0;
                n_halt = 1'b1;
                n_cnt  = cnt;
            end else begin
                n_p0 = np0;
                n_p1 = np1;
                n_n  = nn;
                n_cnt = cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0   <= 8'd0;
            r_p1   <= 8'd0;
            r_n    <= 2'd0;
            r_halt <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_p0   <= n_p0;
            r_p1   <= n_p1;
            r_n    <= n_n;
            r_halt <= n_halt;
            r_cnt  <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/utlf_queue.sv =====
`default_nettype none

module utlf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = utlf_pkg::QueueDepthDefault
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_rdata,
    output logic                  o_full,
    output logic                  o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd, n_wr, n_rd;
    logic [AW:0]      r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = r_cnt == (AW+1)'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_rdata = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        if (do_pop)  n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        if (do_push && !do_pop) n_cnt = r_cnt + 1'b1;
        else if (!do_push && do_pop) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/utlf_back.sv =====
`default_nettype none

module utlf_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire utlf_pkg::t_entry i_head,
    input  wire logic             i_head_valid,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output utlf_pkg::t_res        o_res,
    output logic                  o_last
);
    import utlf_pkg::*;

    logic [1:0] r_idx, n_idx;
    logic       r_valid, n_valid;
    t_res       r_res;
    logic       r_last;
    logic       load, is_last;

    assign load    = i_head_valid && (!r_valid || i_ready);
    assign is_last = r_idx == (i_head.nres - 2'd1);
    assign o_pop   = load && is_last;
    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign o_last  = r_last;

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = is_last ? 2'd0 : r_idx + 2'd1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res  <= i_head.recs[r_idx];
            r_last <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/utf8_to_latin_text_filter_top.sv =====
// Each input byte yields one to three result requests, one per cycle on the output
// while it is ready. The first result request of a byte passes through the queue
// and then the output register before it is valid.
// Throughput is one input byte per cycle while each byte gives one result and the
// output is ready; the result serializer limits the output to one result per cycle.
// Reset is synchronous and active low; it clears the decode state, counters and queue.
`default_nettype none

module utf8_to_latin_text_filter_top #(
    parameter int COUNT_BITS  = utlf_pkg::CountBitsDefault,
    parameter int QUEUE_DEPTH = utlf_pkg::QueueDepthDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // [7:0] latin_byte, [23:8] bytes_accepted
    output logic [1:0]       m_axis_tuser,  // [0] byte_valid, [1] halted
    output logic             m_axis_tlast
);
    import utlf_pkg::*;

    logic   push, pop, full, empty;
    t_entry wentry, head;
    t_res   res;

    utlf_front #(
        .COUNT_BITS(COUNT_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_axis_tvalid),
        .i_data_byte     (s_axis_tdata),
        .i_end_of_buffer (s_axis_tlast),
        .i_queue_full    (full),
        .o_ready         (s_axis_tready),
        .o_push          (push),
        .o_entry         (wentry)
    );

    utlf_queue #(
        .WIDTH($bits(t_entry)),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (wentry),
        .i_pop   (pop),
        .o_rdata (head),
        .o_full  (full),
        .o_empty (empty)
    );

    utlf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (!empty),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_res        (res),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {res.count, res.code};
    assign m_axis_tuser = {res.halted, res.valid};

endmodule

`default_nettype wire

// ===== rtl/utlf_checker.sv =====
`default_nettype none

module utlf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output request changed while stalled");

    a_zero_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'd0)
        else $error("status request carries a nonzero byte");

    a_valid_not_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1] && m_axis_tdata[7:0] != 8'd0)
        else $error("produced byte flagged as halted or zero");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid && s_axis_tready)
        else $error("output valid or input stalled right after reset");

endmodule

bind utf8_to_latin_text_filter_top utlf_checker u_chk (.*);

`default_nettype wire

// ===== dv/latin_text_checker.sv =====
module latin_text_checker #(
    parameter int COUNT_BITS = utlf_pkg::CountBitsDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_tvalid,
    input  wire logic        i_in_tready,
    input  wire logic [7:0]  i_in_tdata,   // [7:0] data_byte
    input  wire logic        i_in_tlast,
    input  wire logic        i_out_tvalid,
    input  wire logic        i_out_tready,
    input  wire logic [23:0] i_out_tdata,  // [7:0] latin_byte, [23:8] bytes_accepted
    input  wire logic [1:0]  i_out_tuser,  // [0] byte_valid, [1] halted
    input  wire logic        i_out_tlast,
    output int               o_fail_count,
    output int               o_outstanding
);
    import utlf_pkg::*;

    localparam longint unsigned CountMax = (64'd1 << COUNT_BITS) - 64'd1;

    typedef struct packed {
        logic [7:0]              code;
        logic                    valid;
        logic                    halted;
        logic [OutCountBits-1:0] count;
        logic                    last;
    } t_latin_rec;

    t_latin_rec        awaited_latin[$];
    t_latin_rec        step_recs[$];
    logic [7:0]        held_lead;
    logic [7:0]        held_mid;
    logic [1:0]        held_count;
    logic              stopped;
    longint unsigned   taken_count;
    int                faults = 0;

    function automatic logic opens_triple(input logic [7:0] b);
        return (b & Lead3Mask) == Lead3Code;
    endfunction

    function automatic logic opens_pair(input logic [7:0] b);
        return (b & Lead2Mask) == Lead2Code;
    endfunction

    function automatic logic is_trailer(input logic [7:0] b);
        return (b & ContMask) == ContCode;
    endfunction

    function automatic logic [7:0] lowered(input logic [7:0] b);
        return (b inside {[8'h41:8'h5a]}) ? (b | 8'h20) : b;
    endfunction

    function automatic logic printable(input logic [7:0] c);
        return c inside {8'h08, 8'h09, 8'h0a, 8'h0d, [8'h20:8'h7e], 8'h80, [8'h82:8'h8d],
                         [8'h92:8'h99], 8'h9c, [8'ha0:8'ha3], [8'ha7:8'ha9], 8'hab, 8'hb0,
                         8'hb4, 8'hb7, 8'hbb, 8'hc0, 8'hc7, 8'hc9, 8'hd6, 8'hd7, 8'hd9,
                         8'hdf, [8'he0:8'he4], [8'he6:8'heb], [8'hed:8'hef], 8'hf4, 8'hf6,
                         [8'hf8:8'hfc]};
    endfunction

    function automatic logic [7:0] pair_code(input logic [7:0] lead, input logic [7:0] tail);
        logic [7:0] v;
        v = 8'h00;
        case (lead)
            8'hc2: begin
                v = {2'b10, tail[5:0]};
                if (v == 8'ha0) v = 8'h20;
            end
            8'hc3: v = {2'b11, tail[5:0]};
            8'hc5: begin
                case (tail)
                    8'h92: v = 8'h8c;
                    8'h93: v = 8'h9c;
                    8'ha0: v = 8'h8a;
                    8'ha1: v = 8'h9a;
                    8'hb8: v = 8'h8f;
                    8'hbd: v = 8'h8e;
                    8'hbe: v = 8'h9e;
                    default: v = 8'h00;
                endcase
            end
            8'hc6: if (tail == 8'h92) v = 8'h83;
            8'hcb: begin
                if (tail == 8'h86) v = 8'h88;
                else if (tail == 8'h9c) v = 8'h98;
            end
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] triple_code(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c);
        case ({a, b, c})
            24'he28093: return 8'h96;
            24'he28094: return 8'h97;
            24'he28098: return 8'h91;
            24'he28099: return 8'h27;
            24'he2809a: return 8'h82;
            24'he2809c: return 8'h93;
            24'he2809d: return 8'h94;
            24'he2809e: return 8'h84;
            24'he280a0: return 8'h86;
            24'he280a1: return 8'h87;
            24'he280a2: return 8'h95;
            24'he280a6: return 8'h85;
            24'he280b0: return 8'h89;
            24'he280b9: return 8'h8b;
            24'he280ba: return 8'h9b;
            24'he282ac: return 8'h80;
            24'he284a2: return 8'h99;
            default:    return 8'h00;
        endcase
    endfunction

    task automatic push_rec(input logic [7:0] code, input logic valid);
        t_latin_rec rec;
        rec.code   = code;
        rec.valid  = valid;
        rec.halted = stopped;
        rec.count  = taken_count[OutCountBits-1:0];
        rec.last   = 1'b0;
        step_recs.push_back(rec);
    endtask

    task automatic emit_code(input logic [7:0] code, input int len);
        if (code == 8'h00 || !printable(code)) begin
            stopped    = 1'b1;
            held_count = 2'd0;
            push_rec(8'h00, 1'b0);
        end else begin
            taken_count = (taken_count + len > CountMax) ? CountMax : taken_count + len;
            push_rec(code, 1'b1);
        end
    endtask

    task automatic take_fresh(input logic [7:0] b);
        if (opens_triple(b) || opens_pair(b)) begin
            held_lead  = b;
            held_count = 2'd1;
        end else begin
            emit_code(lowered(b), 1);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic eob);
        logic [7:0] p0;
        logic [7:0] p1;
        logic [1:0] n;
        t_latin_rec rec;
        p0 = held_lead;
        p1 = held_mid;
        n  = held_count;
        step_recs.delete();
        if (!stopped) begin
            held_count = 2'd0;
            case (n)
                2'd0: take_fresh(b);
                2'd1: begin
                    if (is_trailer(b)) begin
                        if (opens_triple(p0)) begin
                            held_mid   = b;
                            held_count = 2'd2;
                        end else begin
                            emit_code(pair_code(p0, b), 2);
                        end
                    end else begin
                        emit_code(lowered(p0), 1);
                        if (!stopped) take_fresh(b);
                    end
                end
                default: begin
                    if (is_trailer(b)) begin
                        emit_code(triple_code(p0, p1, b), 3);
                    end else begin
                        emit_code(lowered(p0), 1);
                        if (!stopped) emit_code(lowered(p1), 1);
                        if (!stopped) take_fresh(b);
                    end
                end
            endcase
            if (eob && !stopped && held_count != 2'd0) begin
                n          = held_count;
                held_count = 2'd0;
                emit_code(lowered(held_lead), 1);
                if (n == 2'd2 && !stopped) emit_code(lowered(held_mid), 1);
            end
        end
        if (step_recs.size() == 0) push_rec(8'h00, 1'b0);
        rec      = step_recs.pop_back();
        rec.last = 1'b1;
        step_recs.push_back(rec);
        foreach (step_recs[i]) awaited_latin.push_back(step_recs[i]);
        if (eob) begin
            held_count  = 2'd0;
            held_lead   = 8'h00;
            held_mid    = 8'h00;
            stopped     = 1'b0;
            taken_count = 0;
        end
    endtask

    task automatic note_fault(input string what);
        faults++;
        if (faults <= 10) $display("%s", what);
    endtask

    always @(posedge i_clk) begin
        t_latin_rec want;
        t_latin_rec seen;
        if (!i_rst_n) begin
            awaited_latin.delete();
            held_lead   = 8'h00;
            held_mid    = 8'h00;
            held_count  = 2'd0;
            stopped     = 1'b0;
            taken_count = 0;
        end else begin
            // The result is checked before the new request is decoded, so it can never
            // be matched against an expectation raised at the same edge.
            if (i_out_tvalid && i_out_tready) begin
                seen.code   = i_out_tdata[7:0];
                seen.valid  = i_out_tuser[0];
                seen.halted = i_out_tuser[1];
                seen.count  = i_out_tdata[23:8];
                seen.last   = i_out_tlast;
                if (awaited_latin.size() == 0) begin
                    note_fault($sformatf({"unexpected result: code %02h valid %b ",
                                          "halted %b count %0d last %b"},
                                         seen.code, seen.valid, seen.halted, seen.count,
                                         seen.last));
                end else begin
                    want = awaited_latin.pop_front();
                    if (seen !== want) begin
                        note_fault($sformatf({"mismatch: expected code %02h valid %b halted %b ",
                                              "count %0d last %b, got code %02h valid %b ",
                                              "halted %b count %0d last %b"},
                                             want.code, want.valid, want.halted, want.count,
                                             want.last, seen.code, seen.valid, seen.halted,
                                             seen.count, seen.last));
                    end
                end
            end
            if (i_in_tvalid && i_in_tready) decode_byte(i_in_tdata, i_in_tlast);
        end
        o_outstanding <= awaited_latin.size();
        o_fail_count  <= faults;
    end

endmodule

// ===== dv/testbench.sv =====
module testbench;

    localparam int IdleLimit   = 1000;
    localparam int RandomItems = 95;

    localparam logic [7:0]  C5Tails  [7]  = '{8'h92, 8'h93, 8'ha0, 8'ha1, 8'hb8, 8'hbd,
                                              8'hbe};
    localparam logic [15:0] TriTails [17] = '{16'h8093, 16'h8094, 16'h8098, 16'h8099, 16'h809a,
                                              16'h809c, 16'h809d, 16'h809e, 16'h80a0, 16'h80a1,
                                              16'h80a2, 16'h80a6, 16'h80b0, 16'h80b9, 16'h80ba,
                                              16'h82ac, 16'h84a2};

    typedef logic [7:0] t_octets[$];

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] data_byte
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;           // [7:0] latin_byte, [23:8] bytes_accepted
    logic [1:0]  m_axis_tuser;           // [0] byte_valid, [1] halted
    logic        m_axis_tlast;

    int      fail_count;
    int      outstanding;
    int      idle_cycles = 0;
    int      sent_items  = 0;
    bit      tx_steady   = 1'b0;
    bit      rx_steady   = 1'b0;
    t_octets chunk;

    utf8_to_latin_text_filter_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    latin_text_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_tvalid   (s_axis_tvalid),
        .i_in_tready   (s_axis_tready),
        .i_in_tdata    (s_axis_tdata),
        .i_in_tlast    (s_axis_tlast),
        .i_out_tvalid  (m_axis_tvalid),
        .i_out_tready  (m_axis_tready),
        .i_out_tdata   (m_axis_tdata),
        .i_out_tuser   (m_axis_tuser),
        .i_out_tlast   (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    task automatic send_byte(input logic [7:0] data, input logic last);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 15) == 0) tx_steady = !tx_steady;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_items++;
    endtask

    task automatic send_chunk();
        foreach (chunk[i]) send_byte(chunk[i], i == chunk.size() - 1);
    endtask

    // The sender holds off until every result request owed so far has been taken.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic add_char();
        int         pick;
        int         sel;
        logic [7:0] lead;
        logic [15:0] tails;
        pick = $urandom_range(0, 99);
        if (pick < 52) begin
            sel = $urandom_range(0, 11);
            if (sel == 0) chunk.push_back(8'h09);
            else if (sel == 1) chunk.push_back(8'h0a);
            else if (sel == 2) chunk.push_back(8'h0d);
            else chunk.push_back(8'($urandom_range(8'h20, 8'h7e)));
        end else if (pick < 70) begin
            sel = $urandom_range(0, 9);
            if (sel < 2) lead = 8'hc2;
            else if (sel < 7) lead = 8'hc3;
            else if (sel == 7) lead = 8'hc5;
            else if (sel == 8) lead = 8'hc6;
            else lead = 8'hcb;
            chunk.push_back(lead);
            case (lead)
                8'hc5:   chunk.push_back(C5Tails[$urandom_range(0, 6)]);
                8'hc6:   chunk.push_back(8'h92);
                8'hcb:   chunk.push_back($urandom_range(0, 1) ? 8'h86 : 8'h9c);
                default: chunk.push_back(8'($urandom_range(8'h80, 8'hbf)));
            endcase
        end else if (pick < 86) begin
            tails = TriTails[$urandom_range(0, 16)];
            chunk.push_back(8'he2);
            chunk.push_back(tails[15:8]);
            chunk.push_back(tails[7:0]);
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    if ($urandom_range(0, 3) == 0) chunk.push_back(8'h00);
                    else chunk.push_back(8'($urandom_range(0, 255)));
                end
                1: begin
                    chunk.push_back(8'($urandom_range(8'hc0, 8'hef)));
                    chunk.push_back(8'($urandom_range(8'h20, 8'h7e)));
                end
                2: begin
                    chunk.push_back(8'($urandom_range(8'he0, 8'hef)));
                    chunk.push_back(8'($urandom_range(8'h80, 8'hbf)));
                end
                default: chunk.push_back(8'($urandom_range(8'h80, 8'hbf)));
            endcase
        end
    endtask

    initial begin
        int target;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        chunk = {8'h41, 8'h5a, 8'hc3, 8'ha9, 8'he2, 8'h80, 8'h99, 8'hc2, 8'ha0,
                 8'he2, 8'h82, 8'hac};
        send_chunk();
        chunk = {8'he2, 8'h80, 8'h78, 8'hc5};
        send_chunk();
        chunk = {8'hff, 8'h00};
        send_chunk();
        chunk = {8'hc6, 8'h92, 8'he2, 8'h84, 8'ha2, 8'h00};
        send_chunk();
        chunk = {8'he2, 8'h80};
        send_chunk();
        wait_drained();

        sent_items = 0;
        while (sent_items < RandomItems) begin
            chunk.delete();
            target = $urandom_range(1, 10);
            while (chunk.size() < target) add_char();
            send_chunk();
            if ($urandom_range(0, 7) == 0) wait_drained();
        end

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        int stall;
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 14);
            if ($urandom_range(0, 19) == 0) rx_steady = !rx_steady;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IdleLimit) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
